@@ rtl/linear_probe_hash_table_defines.svh @@
// assertion macros for the hash table rtl
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

// property that must hold at every edge outside reset
`define LPHT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition in one cycle implies a condition in the next
`define LPHT_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/lpht_pkg.sv @@
// shared constants and types of the linear probing hash table
package lpht_pkg;

  localparam int unsigned SLOT_COUNT = 101;
  localparam int unsigned SLOT_W     = $clog2(SLOT_COUNT);
  localparam int unsigned REM_W      = SLOT_W + 1;
  localparam int unsigned KEY_W      = 31;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned ST_W       = 2;
  localparam int unsigned RES_W      = 2;

  // floor(2^KEY_W / SLOT_COUNT), quotient estimate is at most one short
  localparam logic [KEY_W-1:0]  RECIP        = KEY_W'((64'd1 << KEY_W) / SLOT_COUNT);
  localparam logic [REM_W-1:0]  SLOT_COUNT_R = REM_W'(SLOT_COUNT);
  localparam logic [SLOT_W-1:0] LAST_SLOT    = SLOT_W'(SLOT_COUNT - 1);

  // queue between front and back, depth a power of two
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = QPTR_W + 1;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  // result status codes
  localparam logic [RES_W-1:0] RES_OK   = 2'd0;
  localparam logic [RES_W-1:0] RES_MISS = 2'd1;
  localparam logic [RES_W-1:0] RES_FULL = 2'd2;

  // slot status codes
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd0;
  localparam logic [ST_W-1:0] ST_USED  = 2'd1;
  localparam logic [ST_W-1:0] ST_TOMB  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic [SLOT_W-1:0] home;
  } job_t;

  typedef struct packed {
    logic [ST_W-1:0]  st;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_t;

  localparam int unsigned SLOT_WORD_W = $bits(slot_t);

endpackage

@@ rtl/lpht_ram.sv @@
// generic single write, single read ram with registered read data
module lpht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/lpht_front.sv @@
// front end: takes words and works out the home slot of each key
module lpht_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  output logic                           full_o,
  input  logic [lpht_pkg::OP_W-1:0]      operation_i,
  input  logic [lpht_pkg::KEY_W-1:0]     key_i,
  input  logic signed [lpht_pkg::VAL_W-1:0] value_i,
  output logic                           job_valid_o,
  output lpht_pkg::job_t                 job_o,
  input  logic                           job_full_i
);

  typedef enum logic [1:0] {FR_IDLE, FR_MUL, FR_RED, FR_PUSH} front_state_e;

  front_state_e state_q, state_d;

  logic [lpht_pkg::OP_W-1:0]    op_q;
  logic [lpht_pkg::KEY_W-1:0]   key_q;
  logic [lpht_pkg::VAL_W-1:0]   val_q;
  logic [2*lpht_pkg::KEY_W-1:0] prod_q;
  logic [lpht_pkg::SLOT_W-1:0]  rem_q;

  logic [lpht_pkg::KEY_W-1:0]  quot;
  logic [lpht_pkg::REM_W-1:0]  back_prod;
  logic [lpht_pkg::REM_W-1:0]  rem_raw;
  logic [lpht_pkg::SLOT_W-1:0] rem_fix;

  // remainder only needs the low bits, it lies below twice the slot count
  assign quot      = prod_q[2*lpht_pkg::KEY_W-1:lpht_pkg::KEY_W];
  assign back_prod = quot[lpht_pkg::REM_W-1:0] * lpht_pkg::SLOT_COUNT_R;
  assign rem_raw   = key_q[lpht_pkg::REM_W-1:0] - back_prod;
  assign rem_fix   = (rem_raw >= lpht_pkg::SLOT_COUNT_R)
                   ? lpht_pkg::SLOT_W'(rem_raw - lpht_pkg::SLOT_COUNT_R)
                   : rem_raw[lpht_pkg::SLOT_W-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      FR_IDLE: if (push_i) state_d = FR_MUL;
      FR_MUL:  state_d = FR_RED;
      FR_RED:  state_d = FR_PUSH;
      FR_PUSH: if (!job_full_i) state_d = FR_IDLE;
      default: state_d = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FR_IDLE && push_i) begin
      op_q  <= operation_i;
      key_q <= key_i;
      val_q <= value_i;
    end
    if (state_q == FR_MUL) begin
      prod_q <= key_q * lpht_pkg::RECIP;
    end
    if (state_q == FR_RED) begin
      rem_q <= rem_fix;
    end
  end

  assign full_o      = (state_q != FR_IDLE);
  assign job_valid_o = (state_q == FR_PUSH);
  assign job_o.op    = op_q;
  assign job_o.key   = key_q;
  assign job_o.value = val_q;
  assign job_o.home  = rem_q;

endmodule

@@ rtl/lpht_queue.sv @@
// short queue of classified jobs between front and back
module lpht_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lpht_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output lpht_pkg::job_t job_o,
  output logic           empty_o
);

  lpht_pkg::job_t entries_q [lpht_pkg::QUEUE_DEPTH];

  logic [lpht_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [lpht_pkg::QCNT_W-1:0] count_q;
  logic                        do_push, do_pop;

  assign full_o  = (count_q == lpht_pkg::QCNT_W'(lpht_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

  assign job_o = entries_q[rd_ptr_q];

endmodule

@@ rtl/lpht_back.sv @@
// back end: probes the slot table and drives the result register
module lpht_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lpht_pkg::job_t                   job_i,
  input  logic                             job_empty_i,
  output logic                             job_pop_o,
  input  logic                             pop_i,
  output logic                             empty_o,
  output logic [lpht_pkg::RES_W-1:0]       status_o,
  output logic signed [lpht_pkg::VAL_W-1:0] found_value_o
);

  typedef enum logic [1:0] {BK_IDLE, BK_PROBE, BK_CHECK, BK_FLUSH} back_state_e;

  back_state_e state_q;

  lpht_pkg::job_t                 job_q;
  logic [lpht_pkg::SLOT_W-1:0]    slot_q, count_q;
  logic [lpht_pkg::RES_W-1:0]     res_status_q, out_status_q;
  logic [lpht_pkg::VAL_W-1:0]     res_found_q, out_found_q;
  logic                           out_valid_q;
  logic [lpht_pkg::SLOT_COUNT-1:0] valid_q;
  logic                           hit_valid_q;

  logic                             ram_we, ram_re;
  lpht_pkg::slot_t                  ram_wdata, rd;
  logic [lpht_pkg::SLOT_WORD_W-1:0] ram_rdata;

  logic [lpht_pkg::ST_W-1:0]   eff_st;
  logic                        is_used, is_tomb, key_hit, last, advance, load_out;
  logic [lpht_pkg::SLOT_W-1:0] next_slot;
  logic [lpht_pkg::RES_W-1:0]  res_status;
  logic [lpht_pkg::VAL_W-1:0]  res_found;
  logic                        known_op;

  lpht_ram #(
    .WIDTH (lpht_pkg::SLOT_WORD_W),
    .DEPTH (lpht_pkg::SLOT_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  // an entry never written reads as empty
  assign rd        = lpht_pkg::slot_t'(ram_rdata);
  assign eff_st    = hit_valid_q ? rd.st : lpht_pkg::ST_EMPTY;
  assign is_used   = (eff_st == lpht_pkg::ST_USED);
  assign is_tomb   = (eff_st == lpht_pkg::ST_TOMB);
  assign key_hit   = is_used && (rd.key == job_q.key);
  assign last      = (count_q == lpht_pkg::LAST_SLOT);
  assign next_slot = (slot_q == lpht_pkg::LAST_SLOT) ? '0 : slot_q + 1'b1;
  assign ram_re    = (state_q == BK_PROBE);
  assign job_pop_o = (state_q == BK_IDLE) && !job_empty_i;
  assign load_out  = (state_q == BK_FLUSH) && (!out_valid_q || pop_i);
  assign known_op  = (job_i.op == lpht_pkg::OP_INSERT) || (job_i.op == lpht_pkg::OP_SEARCH)
                  || (job_i.op == lpht_pkg::OP_DELETE);

  always_comb begin
    ram_we     = 1'b0;
    ram_wdata  = rd;
    advance    = 1'b0;
    res_status = lpht_pkg::RES_MISS;
    res_found  = '0;
    case (job_q.op)
      lpht_pkg::OP_INSERT: begin
        if (!is_used || key_hit) begin
          ram_we     = 1'b1;
          ram_wdata  = '{st: lpht_pkg::ST_USED, key: job_q.key, value: job_q.value};
          res_status = lpht_pkg::RES_OK;
        end else if (last) begin
          res_status = lpht_pkg::RES_FULL;
        end else begin
          advance = 1'b1;
        end
      end
      lpht_pkg::OP_SEARCH: begin
        if (key_hit) begin
          res_status = lpht_pkg::RES_OK;
          res_found  = rd.value;
        end else if ((is_used || is_tomb) && !last) begin
          advance = 1'b1;
        end
      end
      lpht_pkg::OP_DELETE: begin
        if (key_hit) begin
          ram_we     = 1'b1;
          ram_wdata  = '{st: lpht_pkg::ST_TOMB, key: rd.key, value: rd.value};
          res_status = lpht_pkg::RES_OK;
        end else if ((is_used || is_tomb) && !last) begin
          advance = 1'b1;
        end
      end
      default: begin
        res_status = lpht_pkg::RES_MISS;
      end
    endcase
    if (state_q != BK_CHECK) begin
      ram_we  = 1'b0;
      advance = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_IDLE;
      job_q        <= '0;
      slot_q       <= '0;
      count_q      <= '0;
      res_status_q <= lpht_pkg::RES_MISS;
      res_found_q  <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= lpht_pkg::RES_OK;
      out_found_q  <= '0;
      valid_q      <= '0;
    end else begin
      case (state_q)
        BK_IDLE: begin
          if (!job_empty_i) begin
            job_q   <= job_i;
            slot_q  <= job_i.home;
            count_q <= '0;
            if (known_op) begin
              state_q <= BK_PROBE;
            end else begin
              res_status_q <= lpht_pkg::RES_MISS;
              res_found_q  <= '0;
              state_q      <= BK_FLUSH;
            end
          end
        end
        BK_PROBE: state_q <= BK_CHECK;
        BK_CHECK: begin
          if (advance) begin
            slot_q  <= next_slot;
            count_q <= count_q + 1'b1;
            state_q <= BK_PROBE;
          end else begin
            res_status_q <= res_status;
            res_found_q  <= res_found;
            state_q      <= BK_FLUSH;
          end
        end
        BK_FLUSH: if (load_out) state_q <= BK_IDLE;
        default: state_q <= BK_IDLE;
      endcase

      if (ram_we) valid_q[slot_q] <= 1'b1;

      if (load_out) begin
        out_valid_q  <= 1'b1;
        out_status_q <= res_status_q;
        out_found_q  <= res_found_q;
      end else if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      hit_valid_q <= valid_q[slot_q];
    end
  end

  assign empty_o       = !out_valid_q;
  assign status_o      = out_status_q;
  assign found_value_o = out_found_q;

endmodule

@@ rtl/linear_probe_hash_table.sv @@
// Key-value table with open addressing and linear probing, queue-style
// ports on both sides. A word asks for insert, search or delete of a
// 31-bit key; each word gives exactly one result word, in order. The front
// end takes a word, then works out its home slot (key times a reciprocal
// of the slot count, then one correction step) and offers the job to the
// queue, holding it while the queue is full; it takes no new word until
// that job is in the queue. The back end picks up a job, probes slots in
// turn, at most SLOT_COUNT of them on a full wrap (the slot table is one
// memory with registered read, one slot read per probe), and then hands
// the result to the output register, waiting while that still holds an
// unpopped result. Unknown operation codes skip probing and give a miss.
// Slot status comes out of reset as empty at once through one valid flag
// per slot, so there is no clearing pass after reset. A two-deep job
// queue sits between the two ends and the output register holds one
// finished result, so new words keep coming in while a result waits to be
// popped.
`include "linear_probe_hash_table_defines.svh"

module linear_probe_hash_table (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input side
  input  logic                              push,
  output logic                              full,
  input  logic [lpht_pkg::OP_W-1:0]         operation_i,
  input  logic [lpht_pkg::KEY_W-1:0]        key_i,
  input  logic signed [lpht_pkg::VAL_W-1:0] value_i,
  // result side
  output logic                              empty,
  input  logic                              pop,
  output logic [lpht_pkg::RES_W-1:0]        status_o,
  output logic signed [lpht_pkg::VAL_W-1:0] found_value_o
);

  // front to queue
  logic           q_push;
  logic           q_full;
  lpht_pkg::job_t q_in_job;

  // queue to back
  logic           q_pop;
  logic           q_empty;
  lpht_pkg::job_t q_out_job;

  // result word that is not a hit but still carries a value
  logic           stray_value;

  // home slot reduction, one word in flight
  lpht_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .operation_i (operation_i),
    .key_i       (key_i),
    .value_i     (value_i),
    .job_valid_o (q_push),
    .job_o       (q_in_job),
    .job_full_i  (q_full)
  );

  // decouples the reduction from the probe loop
  lpht_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_in_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .job_o   (q_out_job),
    .empty_o (q_empty)
  );

  // probe loop over the slot table, plus the result register
  lpht_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (q_out_job),
    .job_empty_i   (q_empty),
    .job_pop_o     (q_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .status_o      (status_o),
    .found_value_o (found_value_o)
  );

  assign stray_value = !empty && (status_o != lpht_pkg::RES_OK) && (found_value_o != '0);

  // a value is only returned by a successful search
  `LPHT_ASSERT(a_found_only_on_hit, !stray_value, "found value set without a hit")
  // back end never takes a job from an empty queue
  `LPHT_ASSERT(a_pop_not_empty, q_pop |-> !q_empty, "job taken from empty queue")
  // an accepted word keeps the front busy in the next cycle
  `LPHT_ASSERT_NEXT(a_front_busy, push && !full, full, "front free right after accepting a word")
  // a job blocked by a full queue is offered again
  `LPHT_ASSERT_NEXT(a_job_held, q_push && q_full, q_push, "blocked job dropped by front")

endmodule

@@ test/testbench.sv @@
// self-checking testbench for the linear probing hash table, with its own table model
module testbench;
  import lpht_pkg::*;

  // operation code that the block must answer with a miss and leave the table alone
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  // one probe per slot on a full wrap, plus front end and output register
  localparam int unsigned SETTLE_CYCLES = 2 * SLOT_COUNT + 50;
  localparam int unsigned WORD_COUNT    = 1750;
  localparam int unsigned LIGHT_WORDS   = 700;
  localparam int unsigned POOL_SIZE     = 32;
  // largest multiplier that keeps home + SLOT_COUNT * m inside 31 bits
  localparam int unsigned MAX_LAP       = 21262213;

  typedef struct packed {
    logic [RES_W-1:0] status;
    logic [VAL_W-1:0] found;
  } answer_t;

  // one row of the directed part; typed rows carry their answer, the rest use the model
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic             typed;
    logic [RES_W-1:0] status;
    logic [VAL_W-1:0] found;
  } directed_row_t;

  typedef enum logic [1:0] {POP_ALWAYS, POP_COIN, POP_PATTERN, POP_HOLD} pop_mode_e;

  localparam int unsigned DIRECTED_COUNT = 25;
  localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    // empty table straight after reset
    '{OP_SEARCH, 31'd0,          32'h0000_0000, 1'b1, RES_MISS, 32'h0000_0000},
    '{OP_DELETE, 31'h7FFF_FFFF,  32'h0000_0000, 1'b1, RES_MISS, 32'h0000_0000},
    '{OP_SPARE,  31'd5,          32'hFFFF_FFFF, 1'b1, RES_MISS, 32'h0000_0000},
    // key and value extremes
    '{OP_INSERT, 31'd0,          32'h7FFF_FFFF, 1'b1, RES_OK,   32'h0000_0000},
    '{OP_SEARCH, 31'd0,          32'h0000_0000, 1'b1, RES_OK,   32'h7FFF_FFFF},
    '{OP_INSERT, 31'h7FFF_FFFF,  32'h8000_0000, 1'b1, RES_OK,   32'h0000_0000},
    '{OP_SEARCH, 31'h7FFF_FFFF,  32'h0000_0000, 1'b1, RES_OK,   32'h8000_0000},
    // collisions on home slot zero
    '{OP_INSERT, 31'd101,        32'hFFFF_FFFF, 1'b1, RES_OK,   32'h0000_0000},
    '{OP_INSERT, 31'd202,        32'h0000_0001, 1'b1, RES_OK,   32'h0000_0000},
    '{OP_SEARCH, 31'd202,        32'h0000_0000, 1'b1, RES_OK,   32'h0000_0001},
    // overwrite of a present key
    '{OP_INSERT, 31'd0,          32'h0000_0000, 1'b1, RES_OK,   32'h0000_0000},
    '{OP_SEARCH, 31'd0,          32'h0000_0000, 1'b1, RES_OK,   32'h0000_0000},
    // delete leaves a tombstone that search skips
    '{OP_DELETE, 31'd0,          32'h0000_0000, 1'b1, RES_OK,   32'h0000_0000},
    '{OP_SEARCH, 31'd0,          32'h0000_0000, 1'b1, RES_MISS, 32'h0000_0000},
    '{OP_SEARCH, 31'd101,        32'h0000_0000, 1'b1, RES_OK,   32'hFFFF_FFFF},
    // present key behind a tombstone gets a second copy
    '{OP_INSERT, 31'd202,        32'h0000_0005, 1'b0, RES_OK,   32'h0000_0000},
    '{OP_SEARCH, 31'd202,        32'h0000_0000, 1'b0, RES_OK,   32'h0000_0000},
    '{OP_DELETE, 31'd202,        32'h0000_0000, 1'b0, RES_OK,   32'h0000_0000},
    '{OP_SEARCH, 31'd202,        32'h0000_0000, 1'b0, RES_OK,   32'h0000_0000},
    // probing wraps from the last slot to the first
    '{OP_INSERT, 31'd100,        32'h0000_0007, 1'b0, RES_OK,   32'h0000_0000},
    '{OP_INSERT, 31'd201,        32'h0000_0008, 1'b0, RES_OK,   32'h0000_0000},
    '{OP_SEARCH, 31'd201,        32'h0000_0000, 1'b0, RES_OK,   32'h0000_0000},
    '{OP_DELETE, 31'd201,        32'h0000_0000, 1'b0, RES_OK,   32'h0000_0000},
    '{OP_SEARCH, 31'd302,        32'h0000_0000, 1'b0, RES_OK,   32'h0000_0000},
    '{OP_SPARE,  31'h7FFF_FFFF,  32'h0000_0000, 1'b1, RES_MISS, 32'h0000_0000}
  };

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    push        = 1'b0;
  logic                    pop         = 1'b0;
  logic [OP_W-1:0]         operation_i = OP_SEARCH;
  logic [KEY_W-1:0]        key_i       = '0;
  logic signed [VAL_W-1:0] value_i     = '0;
  logic                    full;
  logic                    empty;
  logic [RES_W-1:0]        status_o;
  logic signed [VAL_W-1:0] found_value_o;

  // model of the slot store, kept in step with every accepted word
  logic [ST_W-1:0]  model_state [SLOT_COUNT];
  logic [KEY_W-1:0] model_key   [SLOT_COUNT];
  logic [VAL_W-1:0] model_value [SLOT_COUNT];

  answer_t          pending_answers [$];
  answer_t          oldest_answer;
  logic [KEY_W-1:0] known_keys [$];
  logic [RES_W-1:0] last_status;
  int unsigned      words_sent  = 0;
  int unsigned      burst_left  = 0;
  int unsigned      error_count = 0;

  linear_probe_hash_table u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .operation_i   (operation_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .empty         (empty),
    .pop           (pop),
    .status_o      (status_o),
    .found_value_o (found_value_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // generous ceiling: every word a full wrap plus the longest stalls, several times over
  initial begin
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int unsigned step_slot(int unsigned slot);
    return (slot == SLOT_COUNT - 1) ? 0 : slot + 1;
  endfunction

  // slot holding the key, or SLOT_COUNT when the probe hits an empty slot or wraps
  function automatic int unsigned locate_key(logic [KEY_W-1:0] key);
    int unsigned slot;
    int unsigned n;
    slot = key % SLOT_COUNT;
    for (n = 0; n < SLOT_COUNT; n++) begin
      if (model_state[slot] == ST_USED) begin
        if (model_key[slot] == key) return slot;
      end else if (model_state[slot] != ST_TOMB) begin
        return SLOT_COUNT;
      end
      slot = step_slot(slot);
    end
    return SLOT_COUNT;
  endfunction

  // insert claims the first free or tombstoned slot, no duplicate search beyond it
  function automatic logic [RES_W-1:0] store_key(logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
    int unsigned slot;
    int unsigned n;
    slot = key % SLOT_COUNT;
    for (n = 0; n < SLOT_COUNT; n++) begin
      if (model_state[slot] != ST_USED) begin
        model_state[slot] = ST_USED;
        model_key[slot]   = key;
        model_value[slot] = value;
        return RES_OK;
      end
      if (model_key[slot] == key) begin
        model_value[slot] = value;
        return RES_OK;
      end
      slot = step_slot(slot);
    end
    return RES_FULL;
  endfunction

  function automatic answer_t apply_word(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                         logic [VAL_W-1:0] value);
    answer_t     answer;
    int unsigned slot;
    answer = '{status: RES_MISS, found: '0};
    case (op)
      OP_INSERT: begin
        answer.status = store_key(key, value);
      end
      OP_SEARCH: begin
        slot = locate_key(key);
        if (slot < SLOT_COUNT) begin
          answer.status = RES_OK;
          answer.found  = model_value[slot];
        end
      end
      OP_DELETE: begin
        slot = locate_key(key);
        if (slot < SLOT_COUNT) begin
          model_state[slot] = ST_TOMB;
          answer.status     = RES_OK;
        end
      end
      default: ;
    endcase
    return answer;
  endfunction

  // offer one word, hold it until taken, then maybe open a gap in the burst
  task automatic send_word(logic [OP_W-1:0] op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value,
                           logic typed = 1'b0, answer_t typed_answer = '0);
    answer_t     predicted;
    int unsigned gap;
    @(negedge clk_i);
    push        <= 1'b1;
    operation_i <= op;
    key_i       <= key;
    value_i     <= value;
    do @(posedge clk_i); while (full);
    predicted   = apply_word(op, key, value);
    last_status = predicted.status;
    pending_answers.push_back(typed ? typed_answer : predicted);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        @(negedge clk_i);
        push <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  // stop offering words until every result word has been popped
  task automatic wait_for_results();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [KEY_W-1:0] random_key();
    return KEY_W'($urandom);
  endfunction

  // mostly keys that have been seen, so searches and deletes hit often
  function automatic logic [KEY_W-1:0] choose_key(int unsigned fresh_pct);
    if ($urandom_range(0, 99) < fresh_pct) return random_key();
    return known_keys[$urandom_range(0, known_keys.size() - 1)];
  endfunction

  // random operation over the known keys, inserts adding their key to the set
  task automatic send_mixed(int unsigned insert_pct, int unsigned search_pct,
                            int unsigned fresh_pct);
    int unsigned      pick;
    logic [KEY_W-1:0] key;
    pick = $urandom_range(0, 99);
    key  = choose_key(fresh_pct);
    if (pick < insert_pct) begin
      known_keys.push_back(key);
      send_word(OP_INSERT, key, $urandom);
    end else if (pick < insert_pct + search_pct) begin
      send_word(OP_SEARCH, key, $urandom);
    end else if (pick < 95) begin
      send_word(OP_DELETE, key, $urandom);
    end else begin
      send_word(OP_SPARE, key, $urandom);
    end
  endtask

  // receiver: segments of steady popping, coin flips, a fixed duty pattern and long holds
  initial begin : receiver
    int unsigned seg_len;
    int unsigned n;
    pop_mode_e   mode;
    @(posedge rst_ni);
    forever begin
      seg_len = $urandom_range(10, 150);
      mode    = pop_mode_e'($urandom_range(0, 3));
      for (n = 0; n < seg_len; n++) begin
        @(negedge clk_i);
        case (mode)
          POP_ALWAYS:  pop <= 1'b1;
          POP_COIN:    pop <= 1'($urandom_range(0, 1));
          POP_PATTERN: pop <= ((n % 7) < 2);
          default:     pop <= ((n % 60) >= 50);
        endcase
      end
    end
  end

  // every popped word is checked against the oldest outstanding answer
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_answers.size() == 0) begin
        $error("result word with nothing outstanding: status %0d found_value %0d",
               status_o, found_value_o);
        error_count++;
      end else begin
        oldest_answer = pending_answers.pop_front();
        if (status_o !== oldest_answer.status) begin
          $error("status: expected %0d, actual %0d", oldest_answer.status, status_o);
          error_count++;
        end
        if (found_value_o !== oldest_answer.found) begin
          $error("found_value: expected %0d, actual %0d",
                 $signed(oldest_answer.found), found_value_o);
          error_count++;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned   i;
    int unsigned   full_hits;
    int unsigned   home;
    directed_row_t row;

    for (i = 0; i < SLOT_COUNT; i++) model_state[i] = ST_EMPTY;

    // reset once, released on a falling edge
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    for (i = 0; i < DIRECTED_COUNT; i++) begin
      row = DIRECTED_ROWS[i];
      send_word(row.op, row.key, row.value, row.typed, '{status: row.status, found: row.found});
    end

    // pool of keys crowded onto a few home slots, the last two included to force wraps
    for (i = 0; i < POOL_SIZE; i++) begin
      case ($urandom_range(0, 4))
        0:       home = 0;
        1:       home = SLOT_COUNT - 1;
        2:       home = SLOT_COUNT - 2;
        3:       home = SLOT_COUNT / 2;
        default: home = $urandom_range(0, SLOT_COUNT - 1);
      endcase
      known_keys.push_back(KEY_W'(home + SLOT_COUNT * $urandom_range(0, MAX_LAP)));
    end

    // lightly loaded table: inserts rarely bring a fresh key
    while (words_sent < DIRECTED_COUNT + LIGHT_WORDS) send_mixed(40, 35, 8);

    // let the block run dry once before loading it to the brim
    wait_for_results();

    // fresh keys until the table has refused several inserts
    full_hits = 0;
    for (i = 0; i < 3 * SLOT_COUNT && full_hits < 5; i++) begin
      known_keys.push_back(random_key());
      send_word(OP_INSERT, known_keys[$], $urandom);
      if (last_status == RES_FULL) full_hits++;
    end

    // crowded table: full wraps, refused inserts and tombstones being reclaimed
    while (words_sent < WORD_COUNT) send_mixed(25, 45, 15);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/lpht_pkg.sv
rtl/lpht_ram.sv
rtl/lpht_front.sv
rtl/lpht_queue.sv
rtl/lpht_back.sv
rtl/linear_probe_hash_table.sv
test/testbench.sv
